/* rtl/core/fcc_pkg.sv */
// Shared types and constants for the frustum cull classifier.
package fcc_pkg;

    localparam int NORMAL_BITS = 16;
    localparam int RADIUS_BITS = 23;
    localparam int INDEX_BITS  = 3;
    localparam int CMD_BITS    = 2;
    localparam int CLS_BITS    = 2;

    // sqrt(3) in Q1.16, rounded up
    localparam int         SQRT3_BITS = 17;
    localparam int         SQRT3_FRAC = 16;
    localparam logic [16:0] SQRT3_Q16 = 17'd113512;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_LOAD   = 2'd0,
        CMD_SPHERE = 2'd1,
        CMD_BOX    = 2'd2
    } t_cmd;

    typedef enum logic [CLS_BITS-1:0] {
        CLS_OUTSIDE   = 2'd0,
        CLS_INTERSECT = 2'd1,
        CLS_INSIDE    = 2'd2
    } t_cls;

endpackage

/* rtl/core/fcc_if.sv */
// Input and result channel interfaces of the frustum cull classifier.
interface fcc_in_if #(
    parameter int COORD_BITS = 24
);
    logic                                 valid;
    logic                                 ready;
    logic [fcc_pkg::CMD_BITS-1:0]         cmd;
    logic [fcc_pkg::INDEX_BITS-1:0]       plane_index;
    logic signed [COORD_BITS-1:0]         first_x;
    logic signed [COORD_BITS-1:0]         first_y;
    logic signed [COORD_BITS-1:0]         first_z;
    logic signed [COORD_BITS-1:0]         second_x;
    logic signed [COORD_BITS-1:0]         second_y;
    logic signed [COORD_BITS-1:0]         second_z;
    logic signed [fcc_pkg::NORMAL_BITS-1:0] normal_x;
    logic signed [fcc_pkg::NORMAL_BITS-1:0] normal_y;
    logic signed [fcc_pkg::NORMAL_BITS-1:0] normal_z;
    logic [fcc_pkg::RADIUS_BITS-1:0]      sphere_radius;

    modport source (output valid, cmd, plane_index, first_x, first_y, first_z,
                    second_x, second_y, second_z, normal_x, normal_y, normal_z,
                    sphere_radius, input ready);
    modport sink   (input valid, cmd, plane_index, first_x, first_y, first_z,
                    second_x, second_y, second_z, normal_x, normal_y, normal_z,
                    sphere_radius, output ready);
endinterface

interface fcc_out_if;
    logic                         valid;
    logic                         ready;
    logic [fcc_pkg::CLS_BITS-1:0] classification;
    logic                         visible;

    modport source (output valid, classification, visible, input ready);
    modport sink   (input valid, classification, visible, output ready);
endinterface

/* rtl/core/frustum_cull_classifier.sv */
// An input transfer passes through stages A, B, C, D and E to its result on o_out.
// Throughput: one item per cycle; the whole five-stage pipeline stalls
//   together while a result waits on o_out.ready.
// Load items write the plane registers on leaving the first stage and give no result.
// Reset (synchronous, i_rst_n low) empties the pipeline; plane registers keep
//   their contents and are undefined until loaded.
module frustum_cull_classifier #(
    parameter int NUM_PLANES       = 6,
    parameter int COORD_BITS       = 24,
    parameter int NORMAL_FRAC_BITS = 14
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    fcc_in_if.sink    i_in,
    fcc_out_if.source o_out
);

    localparam int CB  = COORD_BITS;
    localparam int NB  = fcc_pkg::NORMAL_BITS;
    localparam int DW  = CB + 2;             // sphere / doubled-middle difference
    localparam int PDW = CB + 1;             // corner difference
    localparam int PW  = DW + NB;            // sphere product
    localparam int PPW = PDW + NB;           // corner product
    localparam int SW  = PW + 2;             // sphere distance
    localparam int SPW = PPW + 2;            // corner distance
    localparam int XW  = CB + fcc_pkg::SQRT3_BITS;
    localparam int SH  = NORMAL_FRAC_BITS - fcc_pkg::SQRT3_FRAC;
    localparam int SHP = (SH > 0) ? SH : 0;
    localparam int K   = (SH < 0) ? -SH : 0;
    localparam int RBW = XW + SHP;
    localparam int RSW = fcc_pkg::RADIUS_BITS + NORMAL_FRAC_BITS;
    localparam int RW  = (RBW > RSW) ? RBW : RSW;
    localparam int CW  = ((SW > RW + 1) ? SW : RW + 1) + 1;

    logic en;
    assign en = !o_out.valid || o_out.ready;
    assign i_in.ready = en;

    logic signed [CB-1:0] in_lo [3];
    logic signed [CB-1:0] in_hi [3];
    logic signed [NB-1:0] in_nm [3];
    assign in_lo = '{i_in.first_x, i_in.first_y, i_in.first_z};
    assign in_hi = '{i_in.second_x, i_in.second_y, i_in.second_z};
    assign in_nm = '{i_in.normal_x, i_in.normal_y, i_in.normal_z};

    // Stage A: registered item, corner sums and longest side
    logic                              r_a_vld;
    logic [fcc_pkg::CMD_BITS-1:0]      r_a_cmd;
    logic [fcc_pkg::INDEX_BITS-1:0]    r_a_idx;
    logic signed [CB-1:0]              r_a_lo [3];
    logic signed [CB-1:0]              r_a_hi [3];
    logic signed [CB:0]                r_a_sum [3];
    logic signed [NB-1:0]              r_a_nm [3];
    logic [CB-1:0]                     r_a_long;
    logic [fcc_pkg::RADIUS_BITS-1:0]   r_a_rad;
    logic signed [CB:0]                n_a_sum [3];
    logic [CB-1:0]                     n_a_long;

    always_comb begin
        logic signed [CB:0] side;
        n_a_long = '0;
        for (int a = 0; a < 3; a++) begin
            n_a_sum[a] = (CB+1)'(in_lo[a]) + (CB+1)'(in_hi[a]);
            side = (CB+1)'(in_hi[a]) - (CB+1)'(in_lo[a]);
            if (!side[CB] && (side[CB-1:0] > n_a_long)) begin
                n_a_long = side[CB-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in.valid;
        end
        if (en) begin
            r_a_cmd  <= i_in.cmd;
            r_a_idx  <= i_in.plane_index;
            r_a_lo   <= in_lo;
            r_a_hi   <= in_hi;
            r_a_nm   <= in_nm;
            r_a_sum  <= n_a_sum;
            r_a_long <= n_a_long;
            r_a_rad  <= i_in.sphere_radius;
        end
    end

    // Plane store, written and read at the same stage so item order holds
    logic signed [CB-1:0] r_pl_pt [NUM_PLANES][3];
    logic signed [NB-1:0] r_pl_nm [NUM_PLANES][3];

    always_ff @(posedge i_clk) begin
        for (int p = 0; p < NUM_PLANES; p++) begin
            if (en && r_a_vld && (r_a_cmd == fcc_pkg::CMD_LOAD) && (32'(r_a_idx) == p)) begin
                r_pl_pt[p] <= r_a_lo;
                r_pl_nm[p] <= r_a_nm;
            end
        end
    end

    // Stage B: differences against every plane, bounding radius product
    logic                         r_b_vld;
    logic [fcc_pkg::CMD_BITS-1:0] r_b_cmd;
    logic signed [DW-1:0]         r_b_sd [NUM_PLANES][3];
    logic signed [PDW-1:0]        r_b_pd [NUM_PLANES][3];
    logic signed [PDW-1:0]        r_b_nd [NUM_PLANES][3];
    logic signed [NB-1:0]         r_b_nm [NUM_PLANES][3];
    logic [XW-1:0]                r_b_x;
    logic [fcc_pkg::RADIUS_BITS-1:0] r_b_rad;
    logic signed [DW-1:0]         n_b_sd [NUM_PLANES][3];
    logic signed [PDW-1:0]        n_b_pd [NUM_PLANES][3];
    logic signed [PDW-1:0]        n_b_nd [NUM_PLANES][3];

    always_comb begin
        logic is_box;
        logic signed [DW-1:0] pt;
        is_box = (r_a_cmd == fcc_pkg::CMD_BOX);
        for (int p = 0; p < NUM_PLANES; p++) begin
            for (int a = 0; a < 3; a++) begin
                pt = DW'(r_pl_pt[p][a]);
                if (is_box) begin
                    n_b_sd[p][a] = DW'(r_a_sum[a]) - (pt <<< 1);
                end else begin
                    n_b_sd[p][a] = DW'(r_a_lo[a]) - pt;
                end
                // non-negative normal: positive corner takes the max coordinate
                if (!r_pl_nm[p][a][NB-1]) begin
                    n_b_pd[p][a] = PDW'(r_a_hi[a]) - PDW'(r_pl_pt[p][a]);
                    n_b_nd[p][a] = PDW'(r_a_lo[a]) - PDW'(r_pl_pt[p][a]);
                end else begin
                    n_b_pd[p][a] = PDW'(r_a_lo[a]) - PDW'(r_pl_pt[p][a]);
                    n_b_nd[p][a] = PDW'(r_a_hi[a]) - PDW'(r_pl_pt[p][a]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld && ((r_a_cmd == fcc_pkg::CMD_SPHERE) ||
                                   (r_a_cmd == fcc_pkg::CMD_BOX));
        end
        if (en) begin
            r_b_cmd <= r_a_cmd;
            r_b_sd  <= n_b_sd;
            r_b_pd  <= n_b_pd;
            r_b_nd  <= n_b_nd;
            r_b_nm  <= r_pl_nm;
            r_b_x   <= XW'(r_a_long) * XW'(fcc_pkg::SQRT3_Q16);
            r_b_rad <= r_a_rad;
        end
    end

    // Stage C: products and the radius at distance scale
    logic                         r_c_vld;
    logic [fcc_pkg::CMD_BITS-1:0] r_c_cmd;
    logic signed [PW-1:0]         r_c_sp [NUM_PLANES][3];
    logic signed [PPW-1:0]        r_c_pp [NUM_PLANES][3];
    logic signed [PPW-1:0]        r_c_np [NUM_PLANES][3];
    logic [RW-1:0]                r_c_r;
    logic [RW-1:0]                n_c_r;

    always_comb begin
        logic [XW:0] xr;
        xr = {1'b0, r_b_x} + (XW+1)'((64'd1 << K) - 64'd1);
        if (r_b_cmd == fcc_pkg::CMD_BOX) begin
            // round up so the bounding sphere stays conservative
            if (SH < 0) begin
                n_c_r = RW'(xr >> K);
            end else begin
                n_c_r = RW'(r_b_x) << SHP;
            end
        end else begin
            n_c_r = RW'(r_b_rad) << NORMAL_FRAC_BITS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
        if (en) begin
            r_c_cmd <= r_b_cmd;
            r_c_r   <= n_c_r;
            for (int p = 0; p < NUM_PLANES; p++) begin
                for (int a = 0; a < 3; a++) begin
                    r_c_sp[p][a] <= PW'(r_b_sd[p][a]) * PW'(r_b_nm[p][a]);
                    r_c_pp[p][a] <= PPW'(r_b_pd[p][a]) * PPW'(r_b_nm[p][a]);
                    r_c_np[p][a] <= PPW'(r_b_nd[p][a]) * PPW'(r_b_nm[p][a]);
                end
            end
        end
    end

    // Stage D: per-plane distances and compares
    logic                         r_d_vld;
    logic [fcc_pkg::CMD_BITS-1:0] r_d_cmd;
    logic [NUM_PLANES-1:0]        r_d_so, r_d_si, r_d_co, r_d_ci;
    logic [NUM_PLANES-1:0]        n_d_so, n_d_si, n_d_co, n_d_ci;

    always_comb begin
        logic signed [SW-1:0]  ds;
        logic signed [SPW-1:0] dp, dn;
        logic signed [CW-1:0]  dw, rr;
        rr = CW'(r_c_r);
        for (int p = 0; p < NUM_PLANES; p++) begin
            ds = SW'(r_c_sp[p][0]) + SW'(r_c_sp[p][1]) + SW'(r_c_sp[p][2]);
            dp = SPW'(r_c_pp[p][0]) + SPW'(r_c_pp[p][1]) + SPW'(r_c_pp[p][2]);
            dn = SPW'(r_c_np[p][0]) + SPW'(r_c_np[p][1]) + SPW'(r_c_np[p][2]);
            dw = CW'(ds);
            n_d_so[p] = dw < -rr;
            n_d_si[p] = dw < rr;
            n_d_co[p] = dp[SPW-1];
            n_d_ci[p] = dn[SPW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (en) begin
            r_d_vld <= r_c_vld;
        end
        if (en) begin
            r_d_cmd <= r_c_cmd;
            r_d_so  <= n_d_so;
            r_d_si  <= n_d_si;
            r_d_co  <= n_d_co;
            r_d_ci  <= n_d_ci;
        end
    end

    // Stage E: combine planes into the result register
    logic                         r_e_vld;
    logic [fcc_pkg::CLS_BITS-1:0] r_e_cls;
    logic [fcc_pkg::CLS_BITS-1:0] n_e_cls;

    always_comb begin
        if (|r_d_so) begin
            n_e_cls = fcc_pkg::CLS_OUTSIDE;
        end else if (|r_d_si) begin
            n_e_cls = fcc_pkg::CLS_INTERSECT;
        end else begin
            n_e_cls = fcc_pkg::CLS_INSIDE;
        end
        // box straddling the bounding sphere: refine with the corners
        if ((r_d_cmd == fcc_pkg::CMD_BOX) && (n_e_cls == fcc_pkg::CLS_INTERSECT)) begin
            if (|r_d_co) begin
                n_e_cls = fcc_pkg::CLS_OUTSIDE;
            end else if (|r_d_ci) begin
                n_e_cls = fcc_pkg::CLS_INTERSECT;
            end else begin
                n_e_cls = fcc_pkg::CLS_INSIDE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (en) begin
            r_e_vld <= r_d_vld;
        end
        if (en) begin
            r_e_cls <= n_e_cls;
        end
    end

    assign o_out.valid          = r_e_vld;
    assign o_out.classification = r_e_cls;
    assign o_out.visible        = (r_e_cls != fcc_pkg::CLS_OUTSIDE);

endmodule

/* rtl/core/fcc_checker.sv */
// Port-level checks for the frustum cull classifier, bound to the top level.
module fcc_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [fcc_pkg::CLS_BITS-1:0] i_cls,
    input logic                         i_visible
);

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cls))
        else $error("result dropped or changed while stalled");

    a_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_visible == (i_cls != fcc_pkg::CLS_OUTSIDE)))
        else $error("visible disagrees with classification");

    a_cls_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_cls == fcc_pkg::CLS_OUTSIDE ||
                         i_cls == fcc_pkg::CLS_INTERSECT ||
                         i_cls == fcc_pkg::CLS_INSIDE))
        else $error("classification code out of range");

    a_stall_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken while pipeline stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result present after reset");

endmodule

bind frustum_cull_classifier fcc_checker u_fcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_cls       (o_out.classification),
    .i_visible   (o_out.visible)
);
